// ===== rtl/sprite_pixel_tint_blend_defines.svh =====
// Assertion macros shared by the sprite pixel tint and blend RTL.
`ifndef SPRITE_PIXEL_TINT_BLEND_DEFINES_SVH
`define SPRITE_PIXEL_TINT_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sptb_pkg.sv =====
// Package with widths, register indexes, a pixel type and a helper function of the tint and blend block.
`default_nettype none

package sptb_pkg;

    // Payload and register widths.
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned CLIP_W  = 13;
    localparam int unsigned PROD_W  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 3'd7;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
    localparam logic [CLIP_W-1:0] CLIP_MAX = 13'd4096;

    // One ARGB pixel split into channels.
    typedef struct packed {
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } argb_t;

    // Truncated divide by 255 of a product of two bytes (exact up to 65279).
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sptb_in_if.sv =====
// Input channel: texel, destination pixel and target coordinates.
`default_nettype none

interface sptb_in_if;
    logic                              valid;
    logic                              ready;
    logic [sptb_pkg::PIX_W-1:0]        texel;
    logic [sptb_pkg::PIX_W-1:0]        dest_pixel;
    logic [sptb_pkg::COORD_W-1:0]      pixel_x;
    logic [sptb_pkg::COORD_W-1:0]      pixel_y;

    modport source (output valid, texel, dest_pixel, pixel_x, pixel_y, input ready);
    modport sink   (input valid, texel, dest_pixel, pixel_x, pixel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/sptb_out_if.sv =====
// Output channel: write flag and new framebuffer pixel.
`default_nettype none

interface sptb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          write_enable;
    logic [sptb_pkg::PIX_W-1:0]    pixel_out;

    modport source (output valid, write_enable, pixel_out, input ready);
    modport sink   (input valid, write_enable, pixel_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/sprite_pixel_tint_blend.sv =====
// Top level of the sprite pixel tint and source-over blend pipeline.
//
// Usage:
// - pix_in carries one item per accepted handshake: an ARGB texel, the current
//   framebuffer pixel at the target and the target column and row.
// - pix_out returns exactly one item per input item, in order: write_enable and
//   the new ARGB pixel (0 when write_enable is low).
// - The configuration port writes tint, global alpha and clip registers; the user
//   must write it only while the pipeline is empty; the block does not enforce this.
// - The datapath is four register stages (multiply, divide by 255, blend
//   multiply, final divide); one item is accepted every cycle while the
//   output is not stalled.
// - When the receiver stalls, the whole pipeline holds and pix_in.ready is low
//   until the output register is taken; no item is lost or repeated.
// - Reset empties the pipeline and loads identity tint, opaque global alpha
//   and a clip rectangle covering the full 4096 by 4096 area.
`default_nettype none
`include "sprite_pixel_tint_blend_defines.svh"

module sprite_pixel_tint_blend #(
    parameter int unsigned FB_WIDTH  = 4096,
    parameter int unsigned FB_HEIGHT = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    sptb_in_if.sink                                  pix_in,
    sptb_out_if.source                               pix_out,
    input  wire logic                                cfg_we,
    input  wire logic [sptb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sptb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned CW = sptb_pkg::CHAN_W;
    localparam int unsigned PW = sptb_pkg::PROD_W;
    localparam int unsigned LW = sptb_pkg::CLIP_W;
    localparam logic [LW-1:0] FB_W_LIM = LW'(FB_WIDTH);
    localparam logic [LW-1:0] FB_H_LIM = LW'(FB_HEIGHT);

    // Configuration registers.
    logic [CW-1:0] tint_r_reg, tint_g_reg, tint_b_reg, galpha_reg;
    logic [LW-1:0] clip_l_reg, clip_t_reg, clip_r_reg, clip_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_r_reg <= sptb_pkg::CHAN_MAX;
            tint_g_reg <= sptb_pkg::CHAN_MAX;
            tint_b_reg <= sptb_pkg::CHAN_MAX;
            galpha_reg <= sptb_pkg::CHAN_MAX;
            clip_l_reg <= '0;
            clip_t_reg <= '0;
            clip_r_reg <= sptb_pkg::CLIP_MAX;
            clip_b_reg <= sptb_pkg::CLIP_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sptb_pkg::REG_TINT_RED:     tint_r_reg <= cfg_data[CW-1:0];
                sptb_pkg::REG_TINT_GREEN:   tint_g_reg <= cfg_data[CW-1:0];
                sptb_pkg::REG_TINT_BLUE:    tint_b_reg <= cfg_data[CW-1:0];
                sptb_pkg::REG_GLOBAL_ALPHA: galpha_reg <= cfg_data[CW-1:0];
                sptb_pkg::REG_CLIP_LEFT:    clip_l_reg <= cfg_data;
                sptb_pkg::REG_CLIP_TOP:     clip_t_reg <= cfg_data;
                sptb_pkg::REG_CLIP_RIGHT:   clip_r_reg <= cfg_data;
                sptb_pkg::REG_CLIP_BOTTOM:  clip_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves when the output register is empty or taken.
    logic adv;
    logic out_valid_reg;
    assign adv          = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = adv;

    // ---------------- Stage A: visibility and tint/alpha products ----------------
    logic                a_valid_reg, a_valid_next;
    logic                a_wr_reg, a_wr_next;
    logic                a_tint_id_reg, a_tint_id_next;
    logic                a_ga_id_reg, a_ga_id_next;
    sptb_pkg::argb_t     a_texel_reg, a_texel_next;
    sptb_pkg::argb_t     a_dest_reg, a_dest_next;
    logic [PW-1:0]       a_pa_reg, a_pr_reg, a_pg_reg, a_pb_reg;
    logic [PW-1:0]       a_pa_next, a_pr_next, a_pg_next, a_pb_next;
    logic [LW-1:0]       px_ext, py_ext;
    logic                in_frame, in_clip;

    always_comb
    begin
        px_ext       = {1'b0, pix_in.pixel_x};
        py_ext       = {1'b0, pix_in.pixel_y};
        in_frame     = (px_ext < FB_W_LIM) && (py_ext < FB_H_LIM);
        in_clip      = (px_ext >= clip_l_reg) && (px_ext < clip_r_reg) &&
                       (py_ext >= clip_t_reg) && (py_ext < clip_b_reg);
        a_texel_next = pix_in.texel;
        a_dest_next  = pix_in.dest_pixel;
        a_valid_next = pix_in.valid;
        a_wr_next    = in_frame && in_clip && (a_texel_next.a != '0);
        a_tint_id_next = (tint_r_reg == sptb_pkg::CHAN_MAX) &&
                         (tint_g_reg == sptb_pkg::CHAN_MAX) &&
                         (tint_b_reg == sptb_pkg::CHAN_MAX);
        a_ga_id_next = (galpha_reg == sptb_pkg::CHAN_MAX);
        a_pa_next    = PW'(a_texel_next.a) * PW'(galpha_reg);
        a_pr_next    = PW'(a_texel_next.r) * PW'(tint_r_reg);
        a_pg_next    = PW'(a_texel_next.g) * PW'(tint_g_reg);
        a_pb_next    = PW'(a_texel_next.b) * PW'(tint_b_reg);
    end

    // ---------------- Stage B: divide products by 255, select ----------------
    logic                b_valid_reg, b_valid_next;
    logic                b_wr_reg, b_wr_next;
    sptb_pkg::argb_t     b_src_reg, b_src_next;
    sptb_pkg::argb_t     b_dest_reg, b_dest_next;

    always_comb
    begin
        b_valid_next = a_valid_reg;
        b_wr_next    = a_wr_reg;
        b_dest_next  = a_dest_reg;
        b_src_next.a = a_ga_id_reg ? a_texel_reg.a : sptb_pkg::div255(a_pa_reg);
        b_src_next.r = a_tint_id_reg ? a_texel_reg.r : sptb_pkg::div255(a_pr_reg);
        b_src_next.g = a_tint_id_reg ? a_texel_reg.g : sptb_pkg::div255(a_pg_reg);
        b_src_next.b = a_tint_id_reg ? a_texel_reg.b : sptb_pkg::div255(a_pb_reg);
    end

    // ---------------- Stage C: source-over weighted sums ----------------
    logic                c_valid_reg, c_valid_next;
    logic                c_wr_reg, c_wr_next;
    logic                c_opaque_reg, c_opaque_next;
    sptb_pkg::argb_t     c_src_reg, c_src_next;
    logic [PW-1:0]       c_sr_reg, c_sg_reg, c_sb_reg, c_da_reg;
    logic [PW-1:0]       c_sr_next, c_sg_next, c_sb_next, c_da_next;
    logic [CW-1:0]       inv_a;

    always_comb
    begin
        inv_a         = sptb_pkg::CHAN_MAX - b_src_reg.a;
        c_valid_next  = b_valid_reg;
        c_wr_next     = b_wr_reg;
        c_src_next    = b_src_reg;
        c_opaque_next = (b_src_reg.a == sptb_pkg::CHAN_MAX);
        // The two weights add up to 255, so each sum fits in 16 bits.
        c_sr_next = PW'(b_src_reg.r) * PW'(b_src_reg.a) + PW'(b_dest_reg.r) * PW'(inv_a);
        c_sg_next = PW'(b_src_reg.g) * PW'(b_src_reg.a) + PW'(b_dest_reg.g) * PW'(inv_a);
        c_sb_next = PW'(b_src_reg.b) * PW'(b_src_reg.a) + PW'(b_dest_reg.b) * PW'(inv_a);
        c_da_next = PW'(b_dest_reg.a) * PW'(inv_a);
    end

    // ---------------- Stage D: final divide, pack, output register ----------------
    logic                out_valid_next;
    logic                out_we_reg, out_we_next;
    logic [sptb_pkg::PIX_W-1:0] out_pix_reg, out_pix_next;
    sptb_pkg::argb_t     blend;

    always_comb
    begin
        blend.a = c_src_reg.a + sptb_pkg::div255(c_da_reg);
        blend.r = sptb_pkg::div255(c_sr_reg);
        blend.g = sptb_pkg::div255(c_sg_reg);
        blend.b = sptb_pkg::div255(c_sb_reg);
        out_valid_next = c_valid_reg;
        out_we_next    = c_wr_reg;
        if (!c_wr_reg)
        begin
            out_pix_next = '0;
        end
        else if (c_opaque_reg)
        begin
            out_pix_next = c_src_reg;
        end
        else
        begin
            out_pix_next = blend;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_wr_reg      <= a_wr_next;
            a_tint_id_reg <= a_tint_id_next;
            a_ga_id_reg   <= a_ga_id_next;
            a_texel_reg   <= a_texel_next;
            a_dest_reg    <= a_dest_next;
            a_pa_reg      <= a_pa_next;
            a_pr_reg      <= a_pr_next;
            a_pg_reg      <= a_pg_next;
            a_pb_reg      <= a_pb_next;
            b_wr_reg      <= b_wr_next;
            b_src_reg     <= b_src_next;
            b_dest_reg    <= b_dest_next;
            c_wr_reg      <= c_wr_next;
            c_opaque_reg  <= c_opaque_next;
            c_src_reg     <= c_src_next;
            c_sr_reg      <= c_sr_next;
            c_sg_reg      <= c_sg_next;
            c_sb_reg      <= c_sb_next;
            c_da_reg      <= c_da_next;
            out_we_reg    <= out_we_next;
            out_pix_reg   <= out_pix_next;
        end
    end

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.write_enable = out_we_reg;
    assign pix_out.pixel_out    = out_pix_reg;

    // Assertions.
    `SPTB_ASSERT_NOW(a_skip_pixel_zero, clk, rst_n,
        out_valid_reg && !out_we_reg, out_pix_reg == '0,
        "skipped item carries a nonzero pixel")
    `SPTB_ASSERT_NOW(a_ready_only_on_stall, clk, rst_n,
        !pix_in.ready, out_valid_reg && !pix_out.ready,
        "input not ready without an output stall")
    `SPTB_ASSERT_NOW(a_write_needs_alpha, clk, rst_n,
        a_valid_reg && a_wr_reg, a_texel_reg.a != '0,
        "write flagged for a transparent texel")
    `SPTB_ASSERT_NEXT(a_stall_holds_stages, clk, rst_n,
        out_valid_reg && !pix_out.ready,
        $stable(a_valid_reg) && $stable(b_valid_reg) && $stable(c_valid_reg),
        "pipeline stage moved during a stall")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the sprite pixel tint and source-over blend pipeline.

module testbench;
    import sptb_pkg::*;

    localparam int unsigned FB_W        = 4096;
    localparam int unsigned FB_H        = 4096;
    localparam int unsigned LATENCY     = 4;
    localparam int unsigned N_DIR       = 22;
    localparam int unsigned N_PHASES    = 7;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned HOLD_AT     = N_DIR + 4 * PHASE_ITEMS + 40;
    localparam int unsigned HOLD_LEN    = 300;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Shadow copy of the block's configuration registers.
    typedef struct packed {
        logic [CHAN_W-1:0] tint_red;
        logic [CHAN_W-1:0] tint_green;
        logic [CHAN_W-1:0] tint_blue;
        logic [CHAN_W-1:0] global_alpha;
        logic [CLIP_W-1:0] clip_left;
        logic [CLIP_W-1:0] clip_top;
        logic [CLIP_W-1:0] clip_right;
        logic [CLIP_W-1:0] clip_bottom;
    } pix_cfg_t;

    // One framebuffer write decision.
    typedef struct packed {
        logic             write_enable;
        logic [PIX_W-1:0] pixel;
    } pixel_result_t;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic               reconf;
        pix_cfg_t           cfg;
        logic [PIX_W-1:0]   texel;
        logic [PIX_W-1:0]   dest;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               has_ref;
        pixel_result_t      ref_res;
    } pixel_case_t;

    localparam pix_cfg_t CFG_RESET =
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 13'd0, 13'd0, CLIP_MAX, CLIP_MAX};
    localparam pix_cfg_t CFG_BOX =
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 13'd100, 13'd200, 13'd300, 13'd400};
    localparam pix_cfg_t CFG_INVERTED =
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 13'd500, 13'd0, 13'd100, CLIP_MAX};
    localparam pix_cfg_t CFG_LEFT_EDGE =
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, CLIP_MAX, 13'd0, CLIP_MAX, CLIP_MAX};
    localparam pix_cfg_t CFG_TINT_ZERO =
        '{8'h00, 8'h00, 8'h00, 8'hFF, 13'd0, 13'd0, CLIP_MAX, CLIP_MAX};
    localparam pix_cfg_t CFG_TINT_MIX =
        '{8'd128, 8'hFF, 8'h00, 8'hFF, 13'd0, 13'd0, CLIP_MAX, CLIP_MAX};
    localparam pix_cfg_t CFG_GA_ZERO =
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 13'd0, 13'd0, CLIP_MAX, CLIP_MAX};
    localparam pix_cfg_t CFG_GA_HALF =
        '{8'hFF, 8'hFF, 8'hFF, 8'd128, 13'd0, 13'd0, CLIP_MAX, CLIP_MAX};

    // Columns: reconfigure, config, texel, destination, x, y, typed-in result, result.
    localparam pixel_case_t DIRECTED_CASES [N_DIR] = '{
        // Identity settings: opaque, transparent and partial alpha, coordinate extremes.
        '{1'b0, CFG_RESET, 32'hFFFFFFFF, 32'h00000000, 12'd0, 12'd0,
          1'b1, '{1'b1, 32'hFFFFFFFF}},
        '{1'b0, CFG_RESET, 32'hFF000000, 32'hFFFFFFFF, 12'd4095, 12'd4095,
          1'b1, '{1'b1, 32'hFF000000}},
        '{1'b0, CFG_RESET, 32'h00FFFFFF, 32'h12345678, 12'd100, 12'd100,
          1'b1, '{1'b0, 32'h0}},
        '{1'b0, CFG_RESET, 32'h80FF0000, 32'h000000FF, 12'd17, 12'd33, 1'b0, '0},
        '{1'b0, CFG_RESET, 32'h01ABCDEF, 32'hFEDCBA98, 12'd2048, 12'd1024, 1'b0, '0},
        '{1'b0, CFG_RESET, 32'hFE55AA33, 32'h7F00FF80, 12'd1, 12'd4094, 1'b0, '0},
        // Clip rectangle: each of its four borders from both sides.
        '{1'b1, CFG_BOX, 32'hFF112233, 32'h0, 12'd99, 12'd250, 1'b1, '{1'b0, 32'h0}},
        '{1'b0, CFG_BOX, 32'hFF112233, 32'h0, 12'd100, 12'd200,
          1'b1, '{1'b1, 32'hFF112233}},
        '{1'b0, CFG_BOX, 32'hFFA0B0C0, 32'h0, 12'd299, 12'd399,
          1'b1, '{1'b1, 32'hFFA0B0C0}},
        '{1'b0, CFG_BOX, 32'hFF112233, 32'h0, 12'd300, 12'd250, 1'b1, '{1'b0, 32'h0}},
        '{1'b0, CFG_BOX, 32'hFF112233, 32'h0, 12'd150, 12'd400, 1'b1, '{1'b0, 32'h0}},
        '{1'b0, CFG_BOX, 32'hFF112233, 32'h0, 12'd150, 12'd199, 1'b1, '{1'b0, 32'h0}},
        '{1'b0, CFG_BOX, 32'h40FFFFFF, 32'h80000000, 12'd150, 12'd300, 1'b0, '0},
        // Inverted rectangle and a left border at the far edge clip everything.
        '{1'b1, CFG_INVERTED, 32'hFFFFFFFF, 32'h0, 12'd300, 12'd10,
          1'b1, '{1'b0, 32'h0}},
        '{1'b1, CFG_LEFT_EDGE, 32'hFFFFFFFF, 32'h0, 12'd4095, 12'd0,
          1'b1, '{1'b0, 32'h0}},
        // Tint at zero and a mixed tint.
        '{1'b1, CFG_TINT_ZERO, 32'hFFFFFFFF, 32'h0, 12'd5, 12'd5,
          1'b1, '{1'b1, 32'hFF000000}},
        '{1'b0, CFG_TINT_ZERO, 32'h80FFFFFF, 32'hFFFFFFFF, 12'd6, 12'd6, 1'b0, '0},
        '{1'b1, CFG_TINT_MIX, 32'hFF808080, 32'h0, 12'd7, 12'd7, 1'b0, '0},
        // Global alpha of zero writes the destination back unchanged, then half alpha.
        '{1'b1, CFG_GA_ZERO, 32'hFF123456, 32'h89ABCDEF, 12'd8, 12'd8,
          1'b1, '{1'b1, 32'h89ABCDEF}},
        '{1'b0, CFG_GA_ZERO, 32'h00123456, 32'h89ABCDEF, 12'd8, 12'd8,
          1'b1, '{1'b0, 32'h0}},
        '{1'b1, CFG_GA_HALF, 32'hFFFFFFFF, 32'h00000000, 12'd9, 12'd9, 1'b0, '0},
        '{1'b0, CFG_GA_HALF, 32'h01FFFFFF, 32'h11223344, 12'd10, 12'd10, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sptb_in_if  pix_in_ch ();
    sptb_out_if pix_out_ch ();

    pix_cfg_t        active_cfg = CFG_RESET;
    pixel_result_t   pending_writes [$];
    int unsigned     pixels_sent = 0;
    int unsigned     mismatches = 0;
    int unsigned     sender_idle_pct = 0;
    int unsigned     receiver_idle_pct = 0;
    int unsigned     hold_left = 0;
    logic            hold_done = 1'b0;
    int unsigned     cycle_count;

    sprite_pixel_tint_blend #(
        .FB_WIDTH  (FB_W),
        .FB_HEIGHT (FB_H)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in_ch),
        .pix_out   (pix_out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the framebuffer write for one pixel under the current settings.
    function automatic pixel_result_t tint_blend_pixel(input logic [PIX_W-1:0] texel_in,
                                                       input logic [PIX_W-1:0] dest_in,
                                                       input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
        argb_t         src;
        argb_t         dst;
        argb_t         px;
        int unsigned   xa, ya, a, r, g, b, inv;
        pixel_result_t res;
        src = texel_in;
        dst = dest_in;
        xa  = x;
        ya  = y;
        res = '0;
        // Outside the framebuffer, outside the clip rectangle or fully transparent.
        if (xa >= FB_W || ya >= FB_H)
            return res;
        if (xa < active_cfg.clip_left || xa >= active_cfg.clip_right ||
            ya < active_cfg.clip_top || ya >= active_cfg.clip_bottom)
            return res;
        if (src.a == 8'd0)
            return res;
        a = src.a;
        r = src.r;
        g = src.g;
        b = src.b;
        // Scale alpha by the global alpha and colors by the tint, truncating.
        if (active_cfg.global_alpha != CHAN_MAX)
            a = (a * active_cfg.global_alpha) / 255;
        if (active_cfg.tint_red != CHAN_MAX || active_cfg.tint_green != CHAN_MAX ||
            active_cfg.tint_blue != CHAN_MAX)
        begin
            r = (r * active_cfg.tint_red) / 255;
            g = (g * active_cfg.tint_green) / 255;
            b = (b * active_cfg.tint_blue) / 255;
        end
        // Opaque source replaces the destination; anything else blends over it.
        if (a == 255)
        begin
            px.a = CHAN_W'(a);
            px.r = CHAN_W'(r);
            px.g = CHAN_W'(g);
            px.b = CHAN_W'(b);
        end
        else
        begin
            inv  = 255 - a;
            px.r = CHAN_W'((r * a + dst.r * inv) / 255);
            px.g = CHAN_W'((g * a + dst.g * inv) / 255);
            px.b = CHAN_W'((b * a + dst.b * inv) / 255);
            px.a = CHAN_W'(a + (dst.a * inv) / 255);
        end
        res.write_enable = 1'b1;
        res.pixel        = px;
        return res;
    endfunction

    // Random channel value that favors both extremes.
    function automatic logic [CHAN_W-1:0] pick_chan();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 15)
            return 8'h00;
        if (p < 30)
            return CHAN_MAX;
        return CHAN_W'($urandom_range(255));
    endfunction

    // Random clip rectangle that is never empty.
    function automatic pix_cfg_t pick_box(input pix_cfg_t c);
        c.clip_left   = CLIP_W'($urandom_range(3000));
        c.clip_right  = CLIP_W'($urandom_range(FB_W, c.clip_left + 1));
        c.clip_top    = CLIP_W'($urandom_range(3000));
        c.clip_bottom = CLIP_W'($urandom_range(FB_H, c.clip_top + 1));
        return c;
    endfunction

    // Coordinate mostly inside [lo, hi), sometimes on a border or anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned lo,
                                                      input int unsigned hi);
        int unsigned p, top;
        int          v;
        p   = $urandom_range(99);
        top = (hi > 4096) ? 4095 : hi - 1;
        if (p < 15 || hi <= lo || lo > top)
            return COORD_W'($urandom_range(4095));
        if (p < 30)
        begin
            case ($urandom_range(3))
                0:       v = int'(lo) - 1;
                1:       v = int'(lo);
                2:       v = int'(hi) - 1;
                default: v = int'(hi);
            endcase
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            return v[COORD_W-1:0];
        end
        return COORD_W'($urandom_range(top, lo));
    endfunction

    // Writes one configuration register; the strobe stays up for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Loads every register and the shadow copy; called only while the pipeline is empty.
    task automatic load_config(input pix_cfg_t c);
        write_reg(REG_TINT_RED, CFG_DATA_W'(c.tint_red));
        write_reg(REG_TINT_GREEN, CFG_DATA_W'(c.tint_green));
        write_reg(REG_TINT_BLUE, CFG_DATA_W'(c.tint_blue));
        write_reg(REG_GLOBAL_ALPHA, CFG_DATA_W'(c.global_alpha));
        write_reg(REG_CLIP_LEFT, c.clip_left);
        write_reg(REG_CLIP_TOP, c.clip_top);
        write_reg(REG_CLIP_RIGHT, c.clip_right);
        write_reg(REG_CLIP_BOTTOM, c.clip_bottom);
        cfg_we     <= 1'b0;
        active_cfg  = c;
    endtask

    // Stops offering items and waits until every pending write has come out.
    task automatic wait_idle();
        pix_in_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    // Offers one pixel after a random gap and records its write once accepted.
    task automatic send_pixel(input logic [PIX_W-1:0] texel,
                              input logic [PIX_W-1:0] dest,
                              input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y,
                              input logic has_ref,
                              input pixel_result_t ref_res);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            pix_in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        pix_in_ch.valid      <= 1'b1;
        pix_in_ch.texel      <= texel;
        pix_in_ch.dest_pixel <= dest;
        pix_in_ch.pixel_x    <= x;
        pix_in_ch.pixel_y    <= y;
        do
            @(posedge clk);
        while (!pix_in_ch.ready);
        pending_writes.push_back(has_ref ? ref_res : tint_blend_pixel(texel, dest, x, y));
        pixels_sent++;
    endtask

    // Output side: check each accepted item and decide ready for the next cycle.
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && pix_out_ch.valid && pix_out_ch.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected item: write_enable=%0b pixel_out=%h",
                       pix_out_ch.write_enable, pix_out_ch.pixel_out);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (pix_out_ch.write_enable !== want.write_enable)
                begin
                    $error("write_enable mismatch: expected %0b, actual %0b",
                           want.write_enable, pix_out_ch.write_enable);
                    mismatches++;
                end
                if (pix_out_ch.pixel_out !== want.pixel)
                begin
                    $error("pixel_out mismatch: expected %h, actual %h",
                           want.pixel, pix_out_ch.pixel_out);
                    mismatches++;
                end
            end
        end
        // One long hold-off lets the pipeline fill and push back on the input.
        if (hold_left > 0)
        begin
            pix_out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && pixels_sent >= HOLD_AT)
        begin
            pix_out_ch.ready <= 1'b0;
            hold_left         = HOLD_LEN;
            hold_done         = 1'b1;
        end
        else
            pix_out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases with fresh settings.
    initial
    begin
        pix_cfg_t         c;
        logic [PIX_W-1:0] rnd;
        logic [PIX_W-1:0] texel_v;
        logic [CHAN_W-1:0] alpha_v;
        int unsigned      p;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        pix_in_ch.valid      = 1'b0;
        pix_in_ch.texel      = '0;
        pix_in_ch.dest_pixel = '0;
        pix_in_ch.pixel_x    = '0;
        pix_in_ch.pixel_y    = '0;
        pix_out_ch.ready     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver often stalled.
        sender_idle_pct   = 7;
        receiver_idle_pct = 63;

        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIRECTED_CASES[i].reconf)
            begin
                wait_idle();
                load_config(DIRECTED_CASES[i].cfg);
            end
            send_pixel(DIRECTED_CASES[i].texel, DIRECTED_CASES[i].dest,
                       DIRECTED_CASES[i].x, DIRECTED_CASES[i].y,
                       DIRECTED_CASES[i].has_ref, DIRECTED_CASES[i].ref_res);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            if (ph == 2)
            begin
                sender_idle_pct   = 63;
                receiver_idle_pct = 7;
            end
            else if (ph == 4)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            // Settings of this phase, extremes among them.
            c = CFG_RESET;
            case (ph)
                1:
                begin
                    c.tint_red     = pick_chan();
                    c.tint_green   = pick_chan();
                    c.tint_blue    = pick_chan();
                    c.global_alpha = pick_chan();
                    c              = pick_box(c);
                end
                2:
                begin
                    c.tint_red     = $urandom_range(1) ? CHAN_MAX : 8'h00;
                    c.tint_green   = $urandom_range(1) ? CHAN_MAX : 8'h00;
                    c.tint_blue    = $urandom_range(1) ? CHAN_MAX : 8'h00;
                    c.global_alpha = 8'd1;
                end
                3:
                begin
                    c.tint_red     = CHAN_W'($urandom_range(255));
                    c.tint_green   = CHAN_W'($urandom_range(255));
                    c.tint_blue    = CHAN_W'($urandom_range(255));
                    c.global_alpha = CHAN_W'($urandom_range(255));
                    c              = pick_box(c);
                end
                4:
                    c.global_alpha = pick_chan();
                5:
                begin
                    c.tint_red     = 8'd254;
                    c.tint_green   = 8'd254;
                    c.tint_blue    = 8'd254;
                    c.global_alpha = 8'd254;
                    c              = pick_box(c);
                end
                6:
                begin
                    c.tint_red    = pick_chan();
                    c.tint_green  = pick_chan();
                    c.tint_blue   = pick_chan();
                    c.clip_left   = CLIP_W'($urandom_range(4000));
                    c.clip_top    = CLIP_W'($urandom_range(4000));
                end
                default:
                    c = CFG_RESET;
            endcase
            load_config(c);

            // Random pixels, mostly inside the clip rectangle with a visible texel.
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p = $urandom_range(99);
                if (p < 10)
                    alpha_v = 8'h00;
                else if (p < 35)
                    alpha_v = CHAN_MAX;
                else
                    alpha_v = CHAN_W'($urandom_range(254, 1));
                rnd     = $urandom();
                texel_v = {alpha_v, rnd[23:0]};
                send_pixel(texel_v, $urandom(),
                           pick_coord(active_cfg.clip_left, active_cfg.clip_right),
                           pick_coord(active_cfg.clip_top, active_cfg.clip_bottom),
                           1'b0, '0);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sptb_pkg.sv
rtl/sptb_in_if.sv
rtl/sptb_out_if.sv
rtl/sprite_pixel_tint_blend.sv
verif/testbench.sv
